@@ hw/rtl/cbs_pkg.sv @@
package cbs_pkg;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_SEGMENTS = 63;
    localparam int DEF_COORD_WIDTH  = 16;

    // Width of the segment count field of an input item.
    localparam int NSEG_W = 6;

    // Sequencer states, one-hot.
    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_DCUBE  = 6'b000010,
        ST_WEIGHT = 6'b000100,
        ST_MAC    = 6'b001000,
        ST_DIV    = 6'b010000,
        ST_OUT    = 6'b100000
    } t_state;

endpackage

@@ hw/rtl/cubic_bezier_sampler.sv @@
// Cubic Bezier sampler. Each input item holds four signed control points and a
// segment count N, and the block returns N+1 result items, the curve points for
// t = k/N with k running from 0 to N, the last one flagged by o_last. Every point
// is computed exactly as (S(N-k)^3 + 3C1(N-k)^2k + 3C2(N-k)k^2 + Ek^3) / N^3 and
// truncated toward zero, so the first point equals the start point and the last
// equals the end point. An N of zero is treated as one, and an N above
// MAX_SEGMENTS as MAX_SEGMENTS. All arithmetic runs on one shared signed
// multiplier and one restoring divider that yields one quotient bit per cycle,
// under a small sequencer; the block takes no new item until the last point of
// the current one has been taken. For each item the sequencer forms N^3 once;
// for each point it then computes the four Bernstein weights, then per
// coordinate a multiply-accumulate and a division, and then holds the point
// in the output state until it is taken. The bit-serial division dominates
// the time spent per point.
module cubic_bezier_sampler #(
    parameter int MAX_SEGMENTS = cbs_pkg::DEF_MAX_SEGMENTS,
    parameter int COORD_WIDTH  = cbs_pkg::DEF_COORD_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [COORD_WIDTH-1:0] i_start_x,
    input  logic signed [COORD_WIDTH-1:0] i_start_y,
    input  logic signed [COORD_WIDTH-1:0] i_ctrl1_x,
    input  logic signed [COORD_WIDTH-1:0] i_ctrl1_y,
    input  logic signed [COORD_WIDTH-1:0] i_ctrl2_x,
    input  logic signed [COORD_WIDTH-1:0] i_ctrl2_y,
    input  logic signed [COORD_WIDTH-1:0] i_end_x,
    input  logic signed [COORD_WIDTH-1:0] i_end_y,
    input  logic [cbs_pkg::NSEG_W-1:0]    i_num_segments,

    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [COORD_WIDTH-1:0] o_point_x,
    output logic signed [COORD_WIDTH-1:0] o_point_y,
    output logic                          o_last
);

    // Width of a segment count, and of N^3 and the weights.
    localparam int SEGW   = $clog2(MAX_SEGMENTS + 1);
    localparam int WW     = 3 * SEGW;
    // Signed multiplier operand A carries a coordinate or a small count.
    localparam int OPA_W  = (COORD_WIDTH > SEGW) ? COORD_WIDTH : SEGW + 1;
    localparam int PROD_W = OPA_W + WW + 1;
    // Accumulated numerator, signed.
    localparam int NUM_W  = COORD_WIDTH + WW + 1;
    // Step counter must reach COORD_WIDTH+1 in the division phase.
    localparam int STEP_W = $clog2(COORD_WIDTH + 2);
    localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(COORD_WIDTH + 1);

    cbs_pkg::t_state r_state;

    logic [STEP_W-1:0] r_step;
    logic              r_ysel;

    // Control points of the current item, index 0 start .. 3 end.
    logic signed [COORD_WIDTH-1:0] r_ctl_x [4];
    logic signed [COORD_WIDTH-1:0] r_ctl_y [4];

    logic [SEGW-1:0]   r_n;
    logic [SEGW-1:0]   r_k;
    logic [SEGW-1:0]   r_a;
    logic [WW-1:0]     r_den;
    logic [2*SEGW-1:0] r_a2;
    logic [2*SEGW-1:0] r_k2;
    logic [WW-1:0]     r_w0;
    logic [WW-1:0]     r_w1;
    logic [WW-1:0]     r_w2;
    logic [WW-1:0]     r_w3;

    logic signed [PROD_W-1:0] r_prod;
    logic signed [NUM_W-1:0]  r_acc;

    logic [WW-1:0]          r_rem;
    logic [COORD_WIDTH-1:0] r_quo;
    logic                   r_neg;

    logic signed [COORD_WIDTH-1:0] r_px;
    logic signed [COORD_WIDTH-1:0] r_py;

    // Segment count after clamping to the range 1 .. MAX_SEGMENTS.
    logic [31:0]     w_nin;
    logic [31:0]     w_nclamp;
    logic [SEGW-1:0] w_n;

    always_comb begin
        w_nin = 32'(i_num_segments);
        if (w_nin == 32'd0) begin
            w_nclamp = 32'd1;
        end else if (w_nin > 32'(MAX_SEGMENTS)) begin
            w_nclamp = 32'(MAX_SEGMENTS);
        end else begin
            w_nclamp = w_nin;
        end
        w_n = w_nclamp[SEGW-1:0];
    end

    // Shared multiplier operand selection.
    logic signed [OPA_W-1:0] w_mul_a;
    logic [WW-1:0]           w_mul_b;
    logic signed [WW:0]      w_mul_bs;
    logic signed [COORD_WIDTH-1:0] w_coord;

    always_comb begin
        w_coord = r_ysel ? r_ctl_y[r_step[1:0]] : r_ctl_x[r_step[1:0]];
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            cbs_pkg::ST_DCUBE: begin
                w_mul_a = OPA_W'(r_n);
                w_mul_b = (r_step == '0) ? WW'(r_n) : r_prod[WW-1:0];
            end
            cbs_pkg::ST_WEIGHT: begin
                case (r_step)
                    STEP_W'(0): begin
                        w_mul_a = OPA_W'(r_a);
                        w_mul_b = WW'(r_a);
                    end
                    STEP_W'(1): begin
                        w_mul_a = OPA_W'(r_a);
                        w_mul_b = r_prod[WW-1:0];
                    end
                    STEP_W'(2): begin
                        w_mul_a = OPA_W'(r_k);
                        w_mul_b = WW'(r_k);
                    end
                    STEP_W'(3): begin
                        w_mul_a = OPA_W'(r_k);
                        w_mul_b = r_prod[WW-1:0];
                    end
                    STEP_W'(4): begin
                        w_mul_a = OPA_W'(r_k);
                        w_mul_b = WW'(r_a2);
                    end
                    default: begin
                        w_mul_a = OPA_W'(r_a);
                        w_mul_b = WW'(r_k2);
                    end
                endcase
            end
            cbs_pkg::ST_MAC: begin
                w_mul_a = OPA_W'(w_coord);
                case (r_step[1:0])
                    2'd0:    w_mul_b = r_w0;
                    2'd1:    w_mul_b = r_w1;
                    2'd2:    w_mul_b = r_w2;
                    default: w_mul_b = r_w3;
                endcase
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
        w_mul_bs = {1'b0, w_mul_b};
    end

    // Three times the registered product, for the two middle weights.
    logic [WW-1:0] w_prod3;
    assign w_prod3 = r_prod[WW-1:0] + (r_prod[WW-1:0] << 1);

    // Magnitude and sign of the numerator, loaded into the divider.
    logic             w_acc_neg;
    logic [NUM_W-1:0] w_mag;
    assign w_acc_neg = r_acc[NUM_W-1];
    assign w_mag     = w_acc_neg ? NUM_W'(-r_acc) : NUM_W'(r_acc);

    // One restoring division step.
    logic [WW:0] w_trial;
    logic [WW:0] w_diff;
    logic        w_qbit;
    assign w_trial = {r_rem, r_quo[COORD_WIDTH-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_qbit  = ~w_diff[WW];

    logic [COORD_WIDTH-1:0] w_quo_signed;
    assign w_quo_signed = r_neg ? (~r_quo + 1'b1) : r_quo;

    // The product register runs every cycle; consumers pick it up in the cycle after the operands are selected.
    always_ff @(posedge i_clk) begin
        r_prod <= w_mul_a * w_mul_bs;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cbs_pkg::ST_IDLE;
            r_step  <= '0;
            r_ysel  <= 1'b0;
        end else begin
            case (r_state)
                cbs_pkg::ST_IDLE: begin
                    if (i_valid) begin
                        r_ctl_x[0] <= i_start_x;
                        r_ctl_x[1] <= i_ctrl1_x;
                        r_ctl_x[2] <= i_ctrl2_x;
                        r_ctl_x[3] <= i_end_x;
                        r_ctl_y[0] <= i_start_y;
                        r_ctl_y[1] <= i_ctrl1_y;
                        r_ctl_y[2] <= i_ctrl2_y;
                        r_ctl_y[3] <= i_end_y;
                        r_n     <= w_n;
                        r_a     <= w_n;
                        r_k     <= '0;
                        r_step  <= '0;
                        r_ysel  <= 1'b0;
                        r_state <= cbs_pkg::ST_DCUBE;
                    end
                end
                cbs_pkg::ST_DCUBE: begin
                    // Step 0 forms N^2, step 1 forms N^3, step 2 stores it.
                    if (r_step == STEP_W'(2)) begin
                        r_den   <= r_prod[WW-1:0];
                        r_step  <= '0;
                        r_state <= cbs_pkg::ST_WEIGHT;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                cbs_pkg::ST_WEIGHT: begin
                    if (r_step != STEP_W'(6)) begin
                        r_step <= r_step + 1'b1;
                    end
                    case (r_step)
                        STEP_W'(1): r_a2 <= r_prod[2*SEGW-1:0];
                        STEP_W'(2): r_w0 <= r_prod[WW-1:0];
                        STEP_W'(3): r_k2 <= r_prod[2*SEGW-1:0];
                        STEP_W'(4): r_w3 <= r_prod[WW-1:0];
                        STEP_W'(5): r_w1 <= w_prod3;
                        STEP_W'(6): begin
                            r_w2    <= w_prod3;
                            r_step  <= '0;
                            r_ysel  <= 1'b0;
                            r_state <= cbs_pkg::ST_MAC;
                        end
                        default: begin
                        end
                    endcase
                end
                cbs_pkg::ST_MAC: begin
                    if (r_step == STEP_W'(1)) begin
                        r_acc <= NUM_W'(r_prod);
                    end else if (r_step != '0) begin
                        r_acc <= r_acc + NUM_W'(r_prod);
                    end
                    if (r_step == STEP_W'(4)) begin
                        r_step  <= '0;
                        r_state <= cbs_pkg::ST_DIV;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                cbs_pkg::ST_DIV: begin
                    if (r_step != DIV_LAST) begin
                        r_step <= r_step + 1'b1;
                    end
                    if (r_step == '0) begin
                        r_neg <= w_acc_neg;
                        r_rem <= w_mag[COORD_WIDTH+WW-1:COORD_WIDTH];
                        r_quo <= w_mag[COORD_WIDTH-1:0];
                    end else if (r_step == DIV_LAST) begin
                        r_step <= '0;
                        if (r_ysel) begin
                            r_py    <= w_quo_signed;
                            r_state <= cbs_pkg::ST_OUT;
                        end else begin
                            r_px    <= w_quo_signed;
                            r_ysel  <= 1'b1;
                            r_state <= cbs_pkg::ST_MAC;
                        end
                    end else begin
                        r_rem <= w_qbit ? w_diff[WW-1:0] : w_trial[WW-1:0];
                        r_quo <= {r_quo[COORD_WIDTH-2:0], w_qbit};
                    end
                end
                cbs_pkg::ST_OUT: begin
                    if (i_ready) begin
                        if (r_k == r_n) begin
                            r_state <= cbs_pkg::ST_IDLE;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_a     <= r_a - 1'b1;
                            r_step  <= '0;
                            r_ysel  <= 1'b0;
                            r_state <= cbs_pkg::ST_WEIGHT;
                        end
                    end
                end
                default: begin
                    r_state <= cbs_pkg::ST_IDLE;
                end
            endcase
        end
    end

    // No item is taken while reset is held.
    assign o_ready   = i_rst_n && (r_state == cbs_pkg::ST_IDLE);
    assign o_valid   = (r_state == cbs_pkg::ST_OUT);
    assign o_point_x = r_px;
    assign o_point_y = r_py;
    assign o_last    = (r_k == r_n);

endmodule
